FILE: hw/rtl/brw_pkg.sv
// brw_pkg: shared constants, codes and types for battery_resistance_window
// no dependencies; imported by every module of the block except brw_ram
`default_nettype none

package brw_pkg;

    localparam int WINDOW_DEPTH_DEF = 32;

    localparam int PADDR_W  = 5;
    localparam int DATA_W   = 32;
    localparam int SAMPLE_W = 16;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W   = 33;
    localparam int DIV_D_W   = 17;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    localparam logic [MUL_B_W-1:0] SCALE_FACTOR = 17'd100000;
    localparam logic [7:0]         PERCENT_BASE = 8'd100;
    localparam int                 TREND_MIN_SAMPLES = 6;

    localparam logic [16:0] MIN_PEAK_RST  = 17'd500;
    localparam logic [15:0] MIN_DUR_RST   = 16'd500;
    localparam logic [16:0] MIN_STEP_RST  = 17'd300;
    localparam logic [15:0] MAX_RES_RST   = 16'd50000;
    localparam logic [6:0]  TREND_PCT_RST = 7'd10;

    typedef enum logic [2:0] {
        TREND_EMPTY      = 3'd0,
        TREND_COLLECTING = 3'd1,
        TREND_INCREASING = 3'd2,
        TREND_DECREASING = 3'd3,
        TREND_STABLE     = 3'd4
    } trend_t;

    typedef enum logic [2:0] {
        REG_MIN_PEAK   = 3'd0,
        REG_MIN_DUR    = 3'd1,
        REG_MIN_STEP   = 3'd2,
        REG_MAX_RES    = 3'd3,
        REG_TREND_PCT  = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_NUM,
        S_LIM,
        S_DIV,
        S_WALK_INIT,
        S_WALK,
        S_MEAN,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_T5,
        S_T6,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_N_W-1:0]   dividend;
        logic [DIV_D_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_Q_W-1:0]   quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/brw_ram.sv
// brw_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module brw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/brw_mul.sv
// brw_mul: shared multiplier with registered product
// depends on brw_pkg for operand widths
`default_nettype none

module brw_mul (
    input  wire logic                          aclk,
    input  wire logic [brw_pkg::MUL_A_W-1:0]   a,
    input  wire logic [brw_pkg::MUL_B_W-1:0]   b,
    output logic      [brw_pkg::MUL_P_W-1:0]   prod
);
    import brw_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/brw_div.sv
// brw_div: shared restoring divider, one quotient bit per cycle
// depends on brw_pkg; caller guarantees the quotient fits in DIV_Q_W bits
`default_nettype none

module brw_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire brw_pkg::div_req_t req,
    output brw_pkg::div_rsp_t      rsp
);
    import brw_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   sh_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     trial;
    logic                 take;

    assign trial = {rem_reg, sh_reg[DIV_Q_W-1]};
    assign take  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend[DIV_N_W-1:DIV_Q_W];
            sh_reg  <= req.dividend[DIV_Q_W-1:0];
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            if (take) begin
                rem_reg <= DIV_D_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[DIV_D_W-1:0];
            end
            sh_reg <= {sh_reg[DIV_Q_W-2:0], take};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sh_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/battery_resistance_window.sv
// battery_resistance_window: load-event resistance estimate with windowed mean and trend
// depends on brw_pkg, brw_ram, brw_mul, brw_div
//
//   port group   handshake           contents
//   s_*          s_valid / s_ready   one load event
//   m_*          m_valid / m_ready   accepted flag, window mean, trend code, sample count
//   apb          psel / penable      five limit registers at 4*i, pready tied high
//
// an item's processing time grows with the number of samples in the window, and is shorter
// when the event is rejected or the window holds under six samples; it is set by two
// 16-step divides and the walk over the ring's one read port
// s_ready is high only while the sequencer is idle; a finished item waits in the
// output register and a new item is taken meanwhile
// reset clears the sequencer, slot and fill count; the ring needs no clearing pass
`default_nettype none

module battery_resistance_window #(
    parameter int WINDOW_DEPTH = brw_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_pair_found,
    input  wire logic [15:0]                    s_idle_voltage_mv,
    input  wire logic [15:0]                    s_load_voltage_mv,
    input  wire logic signed [17:0]             s_idle_current_ma,
    input  wire logic [16:0]                    s_peak_current_ma,
    input  wire logic [15:0]                    s_duration_ms,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_accepted,
    output logic [15:0]                         m_mean_resistance,
    output logic [2:0]                          m_trend_code,
    output logic [5:0]                          m_sample_count,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [brw_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [brw_pkg::DATA_W-1:0]     pwdata,
    output logic      [brw_pkg::DATA_W-1:0]     prdata,
    output logic                                pready
);
    import brw_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = SAMPLE_W + CW;
    localparam logic [CW-1:0] DEPTH_C     = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT   = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] TREND_MIN_C = CW'(TREND_MIN_SAMPLES);

    state_t state_reg, state_next;

    logic [16:0] cfg_min_peak_reg;
    logic [15:0] cfg_min_dur_reg;
    logic [16:0] cfg_min_step_reg;
    logic [15:0] cfg_max_res_reg;
    logic [6:0]  cfg_trend_pct_reg;

    logic        in_pair_reg;
    logic [15:0] in_v_idle_reg;
    logic [15:0] in_v_load_reg;
    logic [17:0] in_i_idle_reg;
    logic [16:0] in_peak_reg;
    logic [15:0] in_dur_reg;

    logic [AW-1:0] slot_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] cnt_reg;
    logic          pend_reg;
    logic          pend_h1_reg;
    logic [AW-1:0] addr_reg;
    logic [SW-1:0] s1_reg;
    logic [SW-1:0] s2_reg;

    logic [16:0]   step_reg;
    logic [32:0]   num_reg;
    logic [31:0]   pa_reg;
    logic [31:0]   pb_reg;
    logic [39:0]   pa100_reg;
    logic          inc_reg;
    logic          dec_reg;
    logic          acc_reg;
    logic [15:0]   mean_reg;
    trend_t        trend_reg;

    logic          m_valid_reg;
    logic          m_acc_reg;
    logic [15:0]   m_mean_reg;
    logic [2:0]    m_trend_reg;
    logic [5:0]    m_count_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [SAMPLE_W-1:0] ram_rdata;
    logic                ram_we;

    logic [16:0] idle_cl;
    logic [17:0] step_full;
    logic [15:0] drop;
    logic        gate_ok;
    logic [CW-1:0] h1;
    logic [CW-1:0] h2;
    logic          walk_issue;
    logic [CW:0]   start_ext;
    logic [AW-1:0] start_addr;
    logic          out_load;
    logic          cfg_we;
    reg_idx_t      cfg_idx;

    brw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (div_rsp.quotient),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    brw_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    brw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // event gating
    assign idle_cl   = in_i_idle_reg[17] ? 17'd0 : in_i_idle_reg[16:0];
    assign step_full = {1'b0, in_peak_reg} - {1'b0, idle_cl};
    assign drop      = in_v_idle_reg - in_v_load_reg;
    assign gate_ok   = in_pair_reg
                    && (in_peak_reg >= cfg_min_peak_reg)
                    && (in_dur_reg >= cfg_min_dur_reg)
                    && !step_full[17] && (step_full != '0)
                    && (step_full[16:0] >= cfg_min_step_reg)
                    && (in_v_idle_reg > in_v_load_reg);

    // window walk
    assign h1         = count_reg >> 1;
    assign h2         = count_reg - h1;
    assign walk_issue = (state_reg == S_WALK) && (cnt_reg < count_reg);
    assign start_ext  = ({1'b0, CW'(slot_reg)} >= {1'b0, count_reg})
                      ? ({1'b0, CW'(slot_reg)} - {1'b0, count_reg})
                      : ({1'b0, CW'(slot_reg)} + {1'b0, DEPTH_C} - {1'b0, count_reg});
    assign start_addr = start_ext[AW-1:0];

    assign ram_we   = (state_reg == S_DIV) && div_rsp.done;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                mul_a = MUL_A_W'(drop);
                mul_b = SCALE_FACTOR;
                state_next = gate_ok ? S_NUM : S_WALK_INIT;
            end
            S_NUM: begin
                mul_a = MUL_A_W'(cfg_max_res_reg);
                mul_b = step_reg;
                state_next = S_LIM;
            end
            S_LIM: begin
                if ({1'b0, num_reg} <= {1'b0, mul_prod[32:0]}) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num_reg;
                    div_req.divisor  = step_reg;
                    state_next = S_DIV;
                end else begin
                    state_next = S_WALK_INIT;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_WALK_INIT;
                end
            end
            S_WALK_INIT: begin
                state_next = (count_reg == '0) ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (!walk_issue && !pend_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'(s1_reg + s2_reg);
                    div_req.divisor  = DIV_D_W'(count_reg);
                    state_next = S_MEAN;
                end
            end
            S_MEAN: begin
                if (div_rsp.done) begin
                    if (count_reg < TREND_MIN_C) begin
                        state_next = S_DONE;
                    end else begin
                        mul_a = MUL_A_W'(s2_reg);
                        mul_b = MUL_B_W'(h1);
                        state_next = S_T1;
                    end
                end
            end
            S_T1: begin
                mul_a = MUL_A_W'(s1_reg);
                mul_b = MUL_B_W'(h2);
                state_next = S_T2;
            end
            S_T2: begin
                mul_a = pa_reg;
                mul_b = MUL_B_W'(PERCENT_BASE);
                state_next = S_T3;
            end
            S_T3: begin
                mul_a = pb_reg;
                mul_b = MUL_B_W'(PERCENT_BASE + {1'b0, cfg_trend_pct_reg});
                state_next = S_T4;
            end
            S_T4: begin
                mul_a = pb_reg;
                mul_b = MUL_B_W'(PERCENT_BASE - {1'b0, cfg_trend_pct_reg});
                state_next = S_T5;
            end
            S_T5: begin
                mul_a = MUL_A_W'(cfg_trend_pct_reg);
                mul_b = MUL_B_W'(h2);
                state_next = S_T6;
            end
            S_T6: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg          <= '0;
            count_reg         <= '0;
            cnt_reg           <= '0;
            pend_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
            cfg_min_peak_reg  <= MIN_PEAK_RST;
            cfg_min_dur_reg   <= MIN_DUR_RST;
            cfg_min_step_reg  <= MIN_STEP_RST;
            cfg_max_res_reg   <= MAX_RES_RST;
            cfg_trend_pct_reg <= TREND_PCT_RST;
        end else begin
            if (ram_we) begin
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                if (count_reg < DEPTH_C) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (state_reg == S_WALK_INIT) begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end else if (state_reg == S_WALK) begin
                if (walk_issue) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                pend_reg <= walk_issue;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_MIN_PEAK:  cfg_min_peak_reg  <= pwdata[16:0];
                    REG_MIN_DUR:   cfg_min_dur_reg   <= pwdata[15:0];
                    REG_MIN_STEP:  cfg_min_step_reg  <= pwdata[16:0];
                    REG_MAX_RES:   cfg_max_res_reg   <= pwdata[15:0];
                    REG_TREND_PCT: cfg_trend_pct_reg <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_pair_reg   <= s_pair_found;
                    in_v_idle_reg <= s_idle_voltage_mv;
                    in_v_load_reg <= s_load_voltage_mv;
                    in_i_idle_reg <= s_idle_current_ma;
                    in_peak_reg   <= s_peak_current_ma;
                    in_dur_reg    <= s_duration_ms;
                end
            end
            S_CHECK: begin
                step_reg <= step_full[16:0];
                acc_reg  <= 1'b0;
            end
            S_NUM: begin
                num_reg <= mul_prod[32:0];
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    acc_reg <= 1'b1;
                end
            end
            S_WALK_INIT: begin
                addr_reg <= start_addr;
                s1_reg   <= '0;
                s2_reg   <= '0;
                if (count_reg == '0) begin
                    mean_reg  <= '0;
                    trend_reg <= TREND_EMPTY;
                end
            end
            S_WALK: begin
                if (walk_issue) begin
                    addr_reg <= (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                end
                pend_h1_reg <= cnt_reg < h1;
                if (pend_reg) begin
                    if (pend_h1_reg) begin
                        s1_reg <= s1_reg + SW'(ram_rdata);
                    end else begin
                        s2_reg <= s2_reg + SW'(ram_rdata);
                    end
                end
            end
            S_MEAN: begin
                if (div_rsp.done) begin
                    mean_reg  <= div_rsp.quotient;
                    trend_reg <= TREND_COLLECTING;
                end
            end
            S_T1: pa_reg    <= mul_prod[31:0];
            S_T2: pb_reg    <= mul_prod[31:0];
            S_T3: pa100_reg <= mul_prod[39:0];
            S_T4: inc_reg   <= pa100_reg > mul_prod[39:0];
            S_T5: begin
                dec_reg <= ({1'b0, cfg_trend_pct_reg} < PERCENT_BASE)
                        && (pa100_reg < mul_prod[39:0]);
            end
            S_T6: begin
                // empty older half compares the newer mean to the bare percent
                if (s1_reg == '0) begin
                    trend_reg <= (MUL_P_W'(s2_reg) > mul_prod) ? TREND_INCREASING
                                                              : TREND_STABLE;
                end else if (inc_reg) begin
                    trend_reg <= TREND_INCREASING;
                end else if (dec_reg) begin
                    trend_reg <= TREND_DECREASING;
                end else begin
                    trend_reg <= TREND_STABLE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    m_acc_reg   <= acc_reg;
                    m_mean_reg  <= mean_reg;
                    m_trend_reg <= trend_reg;
                    m_count_reg <= 6'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_MIN_PEAK:  prdata = DATA_W'(cfg_min_peak_reg);
            REG_MIN_DUR:   prdata = DATA_W'(cfg_min_dur_reg);
            REG_MIN_STEP:  prdata = DATA_W'(cfg_min_step_reg);
            REG_MAX_RES:   prdata = DATA_W'(cfg_max_res_reg);
            REG_TREND_PCT: prdata = DATA_W'(cfg_trend_pct_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready            = 1'b1;
    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_acc_reg;
    assign m_mean_resistance = m_mean_reg;
    assign m_trend_code      = m_trend_reg;
    assign m_sample_count    = m_count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/brw_checker.sv
// brw_checker: port-level assertions for battery_resistance_window
// depends on brw_pkg for codes; bound to the top level below
`default_nettype none

module brw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_accepted,
    input wire logic [15:0] m_mean_resistance,
    input wire logic [2:0]  m_trend_code,
    input wire logic [5:0]  m_sample_count
);
    import brw_pkg::*;

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_resistance)
                                && $stable(m_trend_code) && $stable(m_sample_count))
        else $error("result item changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while busy");

    a_empty_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_trend_code == TREND_EMPTY) |-> m_mean_resistance == '0)
        else $error("empty window with nonzero mean");

    a_accept_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_trend_code != TREND_EMPTY)
        else $error("accepted sample but window reported empty");

endmodule

bind battery_resistance_window brw_checker u_brw_checker (.*);

`default_nettype wire
